// File: rtl/core/deq_pkg.sv
package deq_pkg;

  // Operation codes carried by in_op
  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_BACK   = 2'd3;

  // Status codes carried by out_status
  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_POP_EMPTY = 2'd1;
  localparam logic [1:0] STAT_PUSH_FULL = 2'd2;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 9;

  typedef struct packed {
    logic [1:0]               status;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
  } deq_result_t;

endpackage

// File: rtl/core/deq_ram.sv
module deq_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic                              re,
  input  logic [AW-1:0]                     addr,
  input  logic [deq_pkg::DATA_W-1:0]        wdata,
  output logic [deq_pkg::DATA_W-1:0]        rdata
);

  logic [deq_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/core/deq_ctrl.sv
module deq_ctrl #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [1:0]                         in_op,
  input  logic signed [deq_pkg::DATA_W-1:0]  in_value,
  output logic                               in_stall,
  input  logic                               res_free,
  output logic                               res_load,
  output deq_pkg::deq_result_t               res,
  output logic                               ram_we,
  output logic                               ram_re,
  output logic [AW-1:0]                      ram_addr,
  output logic [deq_pkg::DATA_W-1:0]         ram_wdata,
  input  logic [deq_pkg::DATA_W-1:0]         ram_rdata
);

  typedef enum logic {ST_IDLE, ST_FIN} state_t;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [AW-1:0]              head_r, head_nxt;
  logic [AW-1:0]              tail_r, tail_nxt;
  logic [deq_pkg::DATA_W-1:0] front_r, front_nxt;
  logic [deq_pkg::DATA_W-1:0] back_r, back_nxt;
  logic [deq_pkg::DATA_W-1:0] popped_r, popped_nxt;
  logic [1:0]                 status_r, status_nxt;
  logic                       rd_front_r, rd_front_nxt;
  logic                       rd_back_r, rd_back_nxt;
  logic [deq_pkg::DATA_W-1:0] front_fin, back_fin;
  logic                       accept, is_empty, is_full, one_left;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] x);
    ring_inc = (x == AW'(DEPTH - 1)) ? '0 : x + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] x);
    ring_dec = (x == '0) ? AW'(DEPTH - 1) : x - AW'(1);
  endfunction

  // Hold the input side during reset and while a request is in flight
  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CW'(DEPTH));
  assign one_left  = (count_r == CW'(1));
  assign res_load  = (state_r == ST_FIN) && res_free;
  assign front_fin = rd_front_r ? ram_rdata : front_r;
  assign back_fin  = rd_back_r ? ram_rdata : back_r;

  always_comb begin
    res.status       = status_r;
    res.count        = deq_pkg::COUNT_W'(count_r);
    res.popped_value = popped_r;
    res.front_value  = is_empty ? '0 : front_fin;
    res.back_value   = is_empty ? '0 : back_fin;
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    front_nxt    = front_r;
    back_nxt     = back_r;
    popped_nxt   = popped_r;
    status_nxt   = status_r;
    rd_front_nxt = rd_front_r;
    rd_back_nxt  = rd_back_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_addr     = head_r;
    ram_wdata    = in_value;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt    = ST_FIN;
          status_nxt   = deq_pkg::STAT_DONE;
          popped_nxt   = '0;
          rd_front_nxt = 1'b0;
          rd_back_nxt  = 1'b0;
          case (in_op)
            deq_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                status_nxt = deq_pkg::STAT_PUSH_FULL;
              end else begin
                head_nxt  = ring_dec(head_r);
                ram_we    = 1'b1;
                ram_addr  = ring_dec(head_r);
                front_nxt = in_value;
                count_nxt = count_r + CW'(1);
                if (is_empty) begin
                  back_nxt = in_value;
                  tail_nxt = ring_dec(head_r);
                end
              end
            end
            deq_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                status_nxt = deq_pkg::STAT_PUSH_FULL;
              end else begin
                tail_nxt  = is_empty ? head_r : ring_inc(tail_r);
                ram_we    = 1'b1;
                ram_addr  = is_empty ? head_r : ring_inc(tail_r);
                back_nxt  = in_value;
                count_nxt = count_r + CW'(1);
                if (is_empty) begin
                  front_nxt = in_value;
                end
              end
            end
            deq_pkg::OP_POP_FRONT: begin
              if (is_empty) begin
                status_nxt = deq_pkg::STAT_POP_EMPTY;
              end else begin
                popped_nxt   = front_r;
                head_nxt     = ring_inc(head_r);
                count_nxt    = count_r - CW'(1);
                ram_addr     = ring_inc(head_r);
                ram_re       = !one_left;
                rd_front_nxt = !one_left;
              end
            end
            deq_pkg::OP_POP_BACK: begin
              if (is_empty) begin
                status_nxt = deq_pkg::STAT_POP_EMPTY;
              end else begin
                popped_nxt  = back_r;
                tail_nxt    = ring_dec(tail_r);
                count_nxt   = count_r - CW'(1);
                ram_addr    = ring_dec(tail_r);
                ram_re      = !one_left;
                rd_back_nxt = !one_left;
              end
            end
            default: begin
              status_nxt = deq_pkg::STAT_DONE;
            end
          endcase
        end
      end
      ST_FIN: begin
        if (res_load) begin
          state_nxt    = ST_IDLE;
          front_nxt    = front_fin;
          back_nxt     = back_fin;
          rd_front_nxt = 1'b0;
          rd_back_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    front_r    <= front_nxt;
    back_r     <= back_nxt;
    popped_r   <= popped_nxt;
    status_r   <= status_nxt;
    rd_front_r <= rd_front_nxt;
    rd_back_r  <= rd_back_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
    end
  end

endmodule

// File: rtl/core/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit values held in one synchronous
// ring memory of DEPTH words. Each request on the in_ channel pushes at the
// front or back or pops from the front or back, and returns exactly one
// result: status, occupancy after the operation (low 9 bits), the popped
// value, and the new front and back values (zero when empty). A pop on an
// empty queue and a push on a full one leave the queue unchanged and report
// a status. The accept cycle writes the pushed word or issues the one memory
// read that a pop needs (the new front or back), and the ST_FIN state then
// collects the read data into the result register once that register is
// free. The front and back words are kept in registers, so only a pop
// touches the read port. A new request is accepted while the previous result
// still waits on out_stall; out_valid rises when a result is loaded.
// Memory contents need no initialization.
module double_ended_queue #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_op,
  input  logic signed [deq_pkg::DATA_W-1:0]  in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_status,
  output logic [deq_pkg::COUNT_W-1:0]        out_count,
  output logic signed [deq_pkg::DATA_W-1:0]  out_popped_value,
  output logic signed [deq_pkg::DATA_W-1:0]  out_front_value,
  output logic signed [deq_pkg::DATA_W-1:0]  out_back_value
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_addr;
  logic [deq_pkg::DATA_W-1:0] ram_wdata, ram_rdata;
  logic                       res_free, res_load;
  deq_pkg::deq_result_t       res;
  deq_pkg::deq_result_t       out_r;
  logic                       out_valid_r;

  // Ring storage
  deq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Head/tail/count bookkeeping and request sequencing
  deq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_value  (in_value),
    .in_stall  (in_stall),
    .res_free  (res_free),
    .res_load  (res_load),
    .res       (res),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  // Output register: take a new result when empty or draining this cycle
  assign res_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_count        = out_r.count;
  assign out_popped_value = out_r.popped_value;
  assign out_front_value  = out_r.front_value;
  assign out_back_value   = out_r.back_value;

  // A rejected request never reports a popped value
  a_reject_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != deq_pkg::STAT_DONE) |-> out_popped_value == '0)
    else $error("rejected request carries a popped value");

  // A pop on empty leaves the queue empty
  a_empty_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == deq_pkg::STAT_POP_EMPTY) |->
      out_count == '0 && out_front_value == '0 && out_back_value == '0)
    else $error("empty pop reports a non-empty queue");

  // An accepted request holds the input side for its collect cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted in back-to-back cycles");

  // A result is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> !(out_valid && out_stall))
    else $error("stalled result overwritten");

endmodule
